// File: sv/kqt_pkg.sv
// ----------------------------------------------------------------------------
// kqt_pkg
// Shared types and codes for the keyed quantity table: commands, status
// codes, sequencer states and the table entry layout.
// ----------------------------------------------------------------------------
package kqt_pkg;

  localparam int unsigned KeyW = 8;
  localparam int unsigned CntW = 7;

  localparam logic [CntW-1:0] CntMax = '1;

  typedef enum logic {
    CMD_ADD    = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_REQ   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic            vld;
    logic [KeyW-1:0] key;
    logic [CntW-1:0] cnt;
  } entry_t;

endpackage

// File: sv/kqt_store.sv
// ----------------------------------------------------------------------------
// kqt_store
// Slot storage: key/count memory with one registered read port and one write
// port, plus per-slot valid flops cleared at reset.
// ----------------------------------------------------------------------------
module kqt_store #(
  parameter int unsigned SLOTS = 16,
  parameter int unsigned IdxW  = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [IdxW-1:0]      rd_addr_i,
  output kqt_pkg::entry_t      rd_entry_o,
  input  logic                 wr_en_i,
  input  logic [IdxW-1:0]      wr_addr_i,
  input  kqt_pkg::entry_t      wr_entry_i
);

  localparam int unsigned DataW = kqt_pkg::KeyW + kqt_pkg::CntW;

  logic [DataW-1:0] mem [SLOTS];
  logic [SLOTS-1:0] vld_q;
  logic [DataW-1:0] rd_data_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_entry_i.key, wr_entry_i.cnt};
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= wr_entry_i.vld;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_entry_o.vld = rd_vld_q;
  assign rd_entry_o.key = rd_data_q[DataW-1 -: kqt_pkg::KeyW];
  assign rd_entry_o.cnt = rd_data_q[kqt_pkg::CntW-1:0];

endmodule

// File: sv/keyed_quantity_table.sv
// ----------------------------------------------------------------------------
// keyed_quantity_table
// Associative quantity table: keyed add/remove with saturation and floor.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one request word: command,
//   item key and signed amount. Output channel (out_valid_o / out_stall_i)
//   returns one response word per request: moved quantity and status.
//   A request is matched by scanning the slot memory one entry per cycle
//   through its single registered read port, then the update state runs the
//   shared add/subtract unit and writes the matched entry back or, for an add
//   of a new key, a new entry into the lowest free slot. A scan ends early on
//   a key hit; a malformed request skips the scan and update. One request is
//   in flight at a time; in_stall_o is low only while the sequencer is idle,
//   so the next request is taken only after the response loads and the
//   sequencer returns to idle.
//   The response sits in an output register, so a new request is taken while
//   the receiver stalls; that request then waits in the done state until the
//   output register frees up.
//   Reset clears all slot valid bits at once (no clearing pass) and empties
//   the output register.
// ----------------------------------------------------------------------------
module keyed_quantity_table #(
  parameter int unsigned SLOTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              command_i,
  input  logic [7:0]        item_key_i,
  input  logic signed [7:0] amount_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [6:0]        moved_o,
  output logic [1:0]        status_o
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);
  localparam int unsigned CntW = kqt_pkg::CntW;

  kqt_pkg::state_e state_q, state_d;

  logic                    cmd_q;
  logic [kqt_pkg::KeyW-1:0] key_q;
  logic signed [7:0]       amt_q;

  logic [IdxW-1:0] scan_q;
  logic            iss_done_q;
  logic            rd_pend_q;
  logic [IdxW-1:0] cur_idx_q;

  logic            hit_q;
  logic [IdxW-1:0] hit_idx_q;
  logic [CntW-1:0] hit_cnt_q;
  logic            free_found_q;
  logic [IdxW-1:0] free_idx_q;

  logic [CntW-1:0] res_moved_q;
  logic [1:0]      res_status_q;

  logic            out_valid_q;
  logic [CntW-1:0] moved_q;
  logic [1:0]      status_q;

  kqt_pkg::entry_t rd_entry;
  kqt_pkg::entry_t wr_entry;
  logic            rd_en;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;

  logic in_acc;
  logic bad_req;
  logic hit_now;
  logic scan_end;
  logic out_free;

  // shared add/subtract unit
  logic            alu_sub;
  logic [CntW:0]   alu_b;
  logic [CntW:0]   alu_res;
  logic [CntW-1:0] amt7;

  assign amt7    = amt_q[CntW-1:0];
  assign alu_sub = (cmd_q == kqt_pkg::CMD_REMOVE);
  assign alu_b   = alu_sub ? ~{1'b0, amt7} : {1'b0, amt7};
  assign alu_res = {1'b0, hit_cnt_q} + alu_b + {{CntW{1'b0}}, alu_sub};

  assign in_acc  = in_valid_i && !in_stall_o;
  assign bad_req = (item_key_i == '0)
                || ((command_i == kqt_pkg::CMD_ADD) && (amount_i <= 8'sd0))
                || ((command_i == kqt_pkg::CMD_REMOVE) && amount_i[7]);

  assign hit_now  = rd_pend_q && rd_entry.vld && (rd_entry.key == key_q);
  assign scan_end = rd_pend_q && (hit_now || (cur_idx_q == LastIdx));
  assign out_free = !out_valid_q || !out_stall_i;

  kqt_store #(
    .SLOTS (SLOTS),
    .IdxW  (IdxW)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr_i  (scan_q),
    .rd_entry_o (rd_entry),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_entry_i (wr_entry)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      kqt_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = bad_req ? kqt_pkg::S_DONE : kqt_pkg::S_SCAN;
        end
      end
      kqt_pkg::S_SCAN: begin
        if (scan_end) begin
          state_d = kqt_pkg::S_UPDATE;
        end
      end
      kqt_pkg::S_UPDATE: state_d = kqt_pkg::S_DONE;
      kqt_pkg::S_DONE: begin
        if (out_free) begin
          state_d = kqt_pkg::S_IDLE;
        end
      end
      default: state_d = kqt_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o     = 1'b1;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = hit_idx_q;
    wr_entry.vld   = 1'b1;
    wr_entry.key   = key_q;
    wr_entry.cnt   = hit_cnt_q;
    case (state_q)
      kqt_pkg::S_IDLE: in_stall_o = 1'b0;
      kqt_pkg::S_SCAN: rd_en = !iss_done_q;
      kqt_pkg::S_UPDATE: begin
        if (hit_q) begin
          wr_en = 1'b1;
          if (alu_sub) begin
            wr_entry.cnt = alu_res[CntW] ? '0 : alu_res[CntW-1:0];
          end else begin
            wr_entry.cnt = alu_res[CntW] ? kqt_pkg::CntMax : alu_res[CntW-1:0];
          end
        end else if (!alu_sub && free_found_q) begin
          wr_en        = 1'b1;
          wr_addr      = free_idx_q;
          wr_entry.cnt = amt7;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= kqt_pkg::S_IDLE;
      iss_done_q   <= 1'b0;
      rd_pend_q    <= 1'b0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        iss_done_q   <= 1'b0;
        rd_pend_q    <= 1'b0;
        hit_q        <= 1'b0;
        free_found_q <= 1'b0;
      end else if (state_q == kqt_pkg::S_SCAN) begin
        rd_pend_q <= !iss_done_q;
        if (!iss_done_q && (scan_q == LastIdx)) begin
          iss_done_q <= 1'b1;
        end
        if (hit_now) begin
          hit_q <= 1'b1;
        end
        // lowest unused slot, kept for a possible new key
        if (rd_pend_q && !rd_entry.vld && !free_found_q) begin
          free_found_q <= 1'b1;
        end
      end
      if (state_q == kqt_pkg::S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q        <= command_i;
      key_q        <= item_key_i;
      amt_q        <= amount_i;
      scan_q       <= '0;
      res_moved_q  <= '0;
      res_status_q <= kqt_pkg::ST_BAD_REQ;
    end else if (state_q == kqt_pkg::S_SCAN) begin
      if (!iss_done_q && (scan_q != LastIdx)) begin
        scan_q <= scan_q + 1'b1;
      end
      cur_idx_q <= scan_q;
      if (hit_now) begin
        hit_idx_q <= cur_idx_q;
        hit_cnt_q <= rd_entry.cnt;
      end
      if (rd_pend_q && !rd_entry.vld && !free_found_q) begin
        free_idx_q <= cur_idx_q;
      end
    end else if (state_q == kqt_pkg::S_UPDATE) begin
      res_status_q <= kqt_pkg::ST_OK;
      res_moved_q  <= '0;
      if (hit_q) begin
        if (alu_sub) begin
          res_moved_q <= alu_res[CntW] ? hit_cnt_q : amt7;
        end else begin
          // saturated: moved is 127 - old
          res_moved_q <= alu_res[CntW] ? ~hit_cnt_q : amt7;
        end
      end else if (alu_sub) begin
        res_status_q <= kqt_pkg::ST_NOT_FOUND;
      end else if (free_found_q) begin
        res_moved_q <= amt7;
      end else begin
        res_status_q <= kqt_pkg::ST_FULL;
      end
    end
    if (state_q == kqt_pkg::S_DONE && out_free) begin
      moved_q  <= res_moved_q;
      status_q <= res_status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign moved_o     = moved_q;
  assign status_o    = status_q;

`ifndef SYNTHESIS
  a_err_moves_nothing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != kqt_pkg::ST_OK) |-> (moved_o == '0))
    else $error("error word carries a nonzero moved quantity");

  a_no_empty_key_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (wr_entry.key != '0) && (state_q == kqt_pkg::S_UPDATE))
    else $error("slot write outside update or with empty key");

  a_scan_ends_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kqt_pkg::S_SCAN) && (state_d == kqt_pkg::S_UPDATE) |-> rd_pend_q)
    else $error("scan left without a read result");

  a_done_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kqt_pkg::S_DONE) && out_free |=> out_valid_q
      && (state_q == kqt_pkg::S_IDLE))
    else $error("response word not loaded on handoff");
`endif

endmodule
